// ===== rtl/core/prefill_dynamic_batcher_core_assert.svh =====
// assertion macros for the prefill batcher core
// used by the sequencer module; expects clock and reset in scope
`ifndef PREFILL_DYNAMIC_BATCHER_CORE_ASSERT_SVH
`define PREFILL_DYNAMIC_BATCHER_CORE_ASSERT_SVH

`define PDB_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pdb check failed");

`define PDB_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pdb check failed");

`endif

// ===== rtl/core/pdb_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the prefill batcher core
// no dependencies
package pdb_pkg;

   localparam int WORKER_COUNT    = 4;
   localparam int QUEUE_DEPTH     = 64;
   localparam int MAX_BATCH_SLOTS = 16;

   localparam int WORKER_W = 2;
   localparam int HEAD_W   = $clog2(QUEUE_DEPTH);
   localparam int LEN_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int CNT_W    = $clog2(MAX_BATCH_SLOTS + 1);
   localparam int SLOT_W   = (MAX_BATCH_SLOTS > 1) ? $clog2(MAX_BATCH_SLOTS) : 1;
   localparam int ADDR_W   = WORKER_W + HEAD_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_DONE    = 2'd2;
   localparam logic [1:0] OP_SPARE   = 2'd3;

   localparam logic [1:0] KIND_ADMIT  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [1:0] REG_ACTIVE = 2'd0;
   localparam logic [1:0] REG_BATCH  = 2'd1;
   localparam logic [1:0] REG_CAP    = 2'd2;
   localparam logic [1:0] REG_WAIT   = 2'd3;

   typedef struct packed {
      logic [2:0]  active_workers;
      logic [4:0]  batch_limit;
      logic [31:0] token_cap;
      logic [39:0] wait_limit_ns;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  out_worker;
      logic [7:0]  out_request;
      logic [31:0] batch_number;
      logic [19:0] tokens_total;
      logic [4:0]  batch_size;
   } res_type;

   typedef struct packed {
      logic    push;
      logic    flush;
      res_type res;
   } push_type;

endpackage

// ===== rtl/core/pdb_csr.sv =====
`timescale 1ns / 1ps
// configuration registers behind the apb-style port
// depends on pdb_pkg
module pdb_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [4:0]      csr_paddr,
   input  logic [63:0]     csr_pwdata,
   output logic [63:0]     csr_prdata,
   output logic            csr_pready,
   output pdb_pkg::cfg_type cfg
);
   import pdb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_paddr[4:3])
            REG_ACTIVE: cfg_in.active_workers = csr_pwdata[2:0];
            REG_BATCH:  cfg_in.batch_limit    = csr_pwdata[4:0];
            REG_CAP:    cfg_in.token_cap      = csr_pwdata[31:0];
            REG_WAIT:   cfg_in.wait_limit_ns  = csr_pwdata[39:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:3])
         REG_ACTIVE: csr_prdata = {61'd0, cfg_ff.active_workers};
         REG_BATCH:  csr_prdata = {59'd0, cfg_ff.batch_limit};
         REG_CAP:    csr_prdata = {32'd0, cfg_ff.token_cap};
         REG_WAIT:   csr_prdata = {24'd0, cfg_ff.wait_limit_ns};
         default:    csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_workers <= 3'd4;
         cfg_ff.batch_limit    <= 5'd1;
         cfg_ff.token_cap      <= 32'd0;
         cfg_ff.wait_limit_ns  <= 40'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/pdb_out.sv =====
`timescale 1ns / 1ps
// result staging: one held word plus the output register, sets the last flag
// depends on pdb_pkg
module pdb_out (
   input  logic              clock,
   input  logic              reset,
   input  pdb_pkg::push_type push,
   output logic              push_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [1:0]        rsp_out_worker,
   output logic [7:0]        rsp_out_request,
   output logic [31:0]       rsp_batch_number,
   output logic [19:0]       rsp_batch_tokens,
   output logic [4:0]        rsp_batch_size,
   output logic              rsp_last
);
   import pdb_pkg::*;

   logic    pend_valid_ff, pend_valid_in;
   res_type pend_ff, pend_in;
   logic    out_valid_ff, out_valid_in;
   res_type out_ff, out_in;
   logic    last_ff, last_in;

   assign push_ready = !out_valid_ff || rsp_ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;
      last_in       = last_ff;
      if (push_ready && push.push) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            last_in      = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = push.res;
      end else if (push_ready && push.flush && pend_valid_ff) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         last_in       = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_ff.kind;
   assign rsp_out_worker   = out_ff.out_worker;
   assign rsp_out_request  = out_ff.out_request;
   assign rsp_batch_number = out_ff.batch_number;
   assign rsp_batch_tokens = out_ff.tokens_total;
   assign rsp_batch_size   = out_ff.batch_size;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/core/pdb_engine.sv =====
`timescale 1ns / 1ps
// queue store and scheduling sequencer: enqueue, done and tick handling
// depends on pdb_pkg and the assertion macro header
`include "prefill_dynamic_batcher_core_assert.svh"
module pdb_engine (
   input  logic              clock,
   input  logic              reset,
   input  pdb_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [1:0]        req_worker_index,
   input  logic [7:0]        req_request_id,
   input  logic [15:0]       req_prompt_tokens,
   input  logic [62:0]       req_time_ns,
   output pdb_pkg::push_type push,
   input  logic              push_ready
);
   import pdb_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_ENQ      = 10'b0000000010,
      S_CHECK    = 10'b0000000100,
      S_DIFF     = 10'b0000001000,
      S_DEC      = 10'b0000010000,
      S_POP      = 10'b0000100000,
      S_POP_WAIT = 10'b0001000000,
      S_EMIT     = 10'b0010000000,
      S_NEXT     = 10'b0100000000,
      S_FLUSH    = 10'b1000000000
   } state_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] tok;
      logic [62:0] arr;
   } entry_type;

   state_type state_ff, state_in;
   logic [HEAD_W-1:0] head_ff [WORKER_COUNT];
   logic [HEAD_W-1:0] head_in [WORKER_COUNT];
   logic [LEN_W-1:0]  len_ff  [WORKER_COUNT];
   logic [LEN_W-1:0]  len_in  [WORKER_COUNT];
   logic [WORKER_COUNT-1:0] busy_ff, busy_in;
   logic [31:0] bn_ff, bn_in;
   logic [2:0]  wk_ff, wk_in;
   logic [62:0] now_ff, now_in;
   logic [63:0] diff_ff, diff_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [19:0] tok_ff, tok_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [7:0]  ids_ff [MAX_BATCH_SLOTS];
   res_type     enq_ff, enq_in;
   entry_type   rd_ff;
   entry_type   mem [MEM_DEPTH];

   logic [WORKER_W-1:0] wk;
   logic [2:0]  nw_eff;
   logic [4:0]  bl_eff;
   logic [CNT_W-1:0] lim;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic        mem_we;
   logic        enq_ok;
   logic        accept;
   logic        go;
   logic        take;
   logic [20:0] tok_sum;
   logic        ids_we;

   assign wk      = wk_ff[WORKER_W-1:0];
   assign nw_eff  = (32'(cfg.active_workers) > WORKER_COUNT) ? 3'(WORKER_COUNT)
                                                           : cfg.active_workers;
   assign bl_eff  = (cfg.batch_limit == 5'd0) ? 5'd1 : cfg.batch_limit;
   assign lim     = (32'(bl_eff) > MAX_BATCH_SLOTS) ? CNT_W'(MAX_BATCH_SLOTS)
                                                    : CNT_W'(bl_eff);
   assign req_ready = (state_ff == S_IDLE);
   assign accept  = req_valid && req_ready;
   assign enq_ok  = (32'(req_worker_index) < WORKER_COUNT)
                    && (32'(len_ff[req_worker_index]) < QUEUE_DEPTH);
   assign mem_we  = accept && (req_opcode == OP_ENQUEUE) && enq_ok;
   assign wr_addr = {req_worker_index,
                     HEAD_W'(32'(head_ff[req_worker_index]) +
                             32'(len_ff[req_worker_index]))};
   assign rd_addr = {wk, head_ff[wk]};

   assign go = (cfg.wait_limit_ns == 40'd0)
               || (len_ff[wk] >= LEN_W'(bl_eff))
               || (!diff_ff[63] && (diff_ff[62:0] >= 63'(cfg.wait_limit_ns)));
   assign tok_sum = 21'(tok_ff) + 21'(rd_ff.tok);
   assign take = (len_ff[wk] != '0) && (cnt_ff < lim)
                 && !((cnt_ff != '0) && (cfg.token_cap != 32'd0)
                      && (32'(tok_sum) > cfg.token_cap));
   assign ids_we = (state_ff == S_POP) && take;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= '{id: req_request_id, tok: req_prompt_tokens, arr: req_time_ns};
      end
      rd_ff <= mem[rd_addr];
      if (ids_we) begin
         ids_ff[cnt_ff[SLOT_W-1:0]] <= rd_ff.id;
      end
   end

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      len_in   = len_ff;
      busy_in  = busy_ff;
      bn_in    = bn_ff;
      wk_in    = wk_ff;
      now_in   = now_ff;
      diff_in  = diff_ff;
      cnt_in   = cnt_ff;
      tok_in   = tok_ff;
      idx_in   = idx_ff;
      enq_in   = enq_ff;
      push     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_ENQUEUE: begin
                     enq_in = '0;
                     enq_in.kind = enq_ok ? KIND_ACCEPT : KIND_REJECT;
                     enq_in.out_worker  = req_worker_index;
                     enq_in.out_request = req_request_id;
                     if (enq_ok) begin
                        len_in[req_worker_index] = len_ff[req_worker_index] + 1'b1;
                     end
                     state_in = S_ENQ;
                  end
                  OP_TICK: begin
                     now_in   = req_time_ns;
                     wk_in    = 3'd0;
                     state_in = (nw_eff == 3'd0) ? S_FLUSH : S_CHECK;
                  end
                  OP_DONE: begin
                     if (32'(req_worker_index) < WORKER_COUNT) begin
                        busy_in[req_worker_index] = 1'b0;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_ENQ: begin
            push.push = 1'b1;
            push.res  = enq_ff;
            if (push_ready) begin
               state_in = S_FLUSH;
            end
         end
         S_CHECK: begin
            state_in = (busy_ff[wk] || len_ff[wk] == '0) ? S_NEXT : S_DIFF;
         end
         S_DIFF: begin
            diff_in  = {1'b0, now_ff} - {1'b0, rd_ff.arr};
            state_in = S_DEC;
         end
         S_DEC: begin
            cnt_in   = '0;
            tok_in   = 20'd0;
            state_in = go ? S_POP : S_NEXT;
         end
         S_POP: begin
            if (take) begin
               tok_in      = tok_sum[19:0];
               head_in[wk] = head_ff[wk] + 1'b1;
               len_in[wk]  = len_ff[wk] - 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               state_in    = S_POP_WAIT;
            end else begin
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_POP_WAIT: state_in = S_POP;
         S_EMIT: begin
            push.push             = 1'b1;
            push.res.kind         = KIND_ADMIT;
            push.res.out_worker   = wk;
            push.res.out_request  = ids_ff[idx_ff];
            push.res.batch_number = bn_ff;
            push.res.tokens_total = tok_ff;
            push.res.batch_size   = 5'(cnt_ff);
            if (push_ready) begin
               if (CNT_W'(idx_ff) + 1'b1 == cnt_ff) begin
                  busy_in[wk] = 1'b1;
                  bn_in       = bn_ff + 32'd1;
                  state_in    = S_NEXT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_NEXT: begin
            if (wk_ff == nw_eff - 3'd1) begin
               state_in = S_FLUSH;
            end else begin
               wk_in    = wk_ff + 3'd1;
               state_in = S_CHECK;
            end
         end
         S_FLUSH: begin
            push.flush = 1'b1;
            if (push_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= '0;
         bn_ff    <= 32'd0;
         wk_ff    <= 3'd0;
         for (int i = 0; i < WORKER_COUNT; i++) begin
            head_ff[i] <= '0;
            len_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         bn_ff    <= bn_in;
         wk_ff    <= wk_in;
         head_ff  <= head_in;
         len_ff   <= len_in;
      end
      now_ff  <= now_in;
      diff_ff <= diff_in;
      cnt_ff  <= cnt_in;
      tok_ff  <= tok_in;
      idx_ff  <= idx_in;
      enq_ff  <= enq_in;
   end

   `PDB_CHECK(a_emit_nonempty, state_ff == S_EMIT, cnt_ff != '0 && cnt_ff <= lim)
   `PDB_CHECK(a_launch_idle, state_ff == S_DEC, !busy_ff[wk] && len_ff[wk] != '0)
   `PDB_CHECK_NEXT(a_batch_marks_busy,
      state_ff == S_EMIT && push_ready && CNT_W'(idx_ff) + 1'b1 == cnt_ff,
      busy_ff[wk] && state_ff == S_NEXT)

endmodule

// ===== rtl/core/prefill_dynamic_batcher_core.sv =====
`timescale 1ns / 1ps
// prefill batcher core: per-worker request queues and batch launch scheduling
// depends on pdb_pkg, pdb_csr, pdb_engine and pdb_out
//
// req_ channel takes one word per operation: enqueue, schedule tick or worker
// done. rsp_ channel returns result words; rsp_last marks the final word of
// an operation. An enqueue gives one word, a done none, a tick one word per
// admitted request (none if nothing launches).
// An enqueue passes through the enqueue and flush states before the next word is
// taken; a done completes in the idle state. A tick visits each active worker in
// turn, examines an idle, non-empty worker against its head wait, then pops the
// batch one request at a time, sends one result word per request and closes
// with a flush, all through one shared sequencer and a queue store with one
// write and one read port.
// req_ready is low while an operation is in progress.
// A stalled rsp_ready holds the output register and the sequencer waits.
// Reset empties all queues, marks all workers idle and restores registers:
// active_workers 4, batch_limit 1, token_cap 0, wait_limit_ns 0.
// Registers sit at byte offsets 0, 8, 16 and 24 of the 64-bit csr_ port.
module prefill_dynamic_batcher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_worker_index,
   input  logic [7:0]  req_request_id,
   input  logic [15:0] req_prompt_tokens,
   input  logic [62:0] req_time_ns,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_out_worker,
   output logic [7:0]  rsp_out_request,
   output logic [31:0] rsp_batch_number,
   output logic [19:0] rsp_batch_tokens,
   output logic [4:0]  rsp_batch_size,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import pdb_pkg::*;

   cfg_type  cfg;
   push_type push;
   logic     push_ready;

   pdb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pdb_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_worker_index  (req_worker_index),
      .req_request_id    (req_request_id),
      .req_prompt_tokens (req_prompt_tokens),
      .req_time_ns       (req_time_ns),
      .push              (push),
      .push_ready        (push_ready)
   );

   pdb_out u_out (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .push_ready       (push_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_worker   (rsp_out_worker),
      .rsp_out_request  (rsp_out_request),
      .rsp_batch_number (rsp_batch_number),
      .rsp_batch_tokens (rsp_batch_tokens),
      .rsp_batch_size   (rsp_batch_size),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== tb/tb_prefill_dynamic_batcher_core.sv =====
`timescale 1ns / 1ps
// self-checking testbench for prefill_dynamic_batcher_core: directed table then random words
// depends on pdb_pkg and the core; predictor mirrors per-worker queues and launch rules
module tb_prefill_dynamic_batcher_core;
   import pdb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_ENQUEUE;
   logic [1:0]  req_worker_index = '0;
   logic [7:0]  req_request_id = '0;
   logic [15:0] req_prompt_tokens = '0;
   logic [62:0] req_time_ns = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_out_worker;
   logic [7:0]  rsp_out_request;
   logic [31:0] rsp_batch_number;
   logic [19:0] rsp_batch_tokens;
   logic [4:0]  rsp_batch_size;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   prefill_dynamic_batcher_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct {
      logic [1:0]  kind;
      logic [1:0]  worker;
      logic [7:0]  request;
      logic [31:0] bnum;
      logic [19:0] btok;
      logic [4:0]  bsize;
      logic        last;
   } word_type;

   typedef struct {
      logic [1:0]  op;
      logic [1:0]  worker;
      logic [7:0]  id;
      logic [15:0] tokens;
      logic [62:0] tnow;
      logic        typed;
      logic [1:0]  xkind;
   } row_type;

   // predictor state
   logic [2:0]  cfg_active = 3'd4;
   logic [4:0]  cfg_batch = 5'd1;
   logic [31:0] cfg_cap = '0;
   logic [39:0] cfg_wait = '0;
   logic [7:0]  q_id [WORKER_COUNT][$];
   logic [15:0] q_tok [WORKER_COUNT][$];
   logic [62:0] q_arr [WORKER_COUNT][$];
   logic        busy [WORKER_COUNT];
   logic [31:0] next_bnum = '0;

   word_type expected_words[$];
   int    errors = 0;
   bit    calm = 1'b0;
   bit    rsp_idle_on = 1'b1;

   function automatic void launch_batch(int w);
      int lim;
      int cnt;
      logic [63:0] sum;
      logic [7:0] ids[$];
      word_type x;
      lim = (cfg_batch == 0) ? 1 : (cfg_batch > MAX_BATCH_SLOTS ? MAX_BATCH_SLOTS : cfg_batch);
      cnt = 0;
      sum = 0;
      while (q_id[w].size() > 0 && cnt < lim) begin
         if (cnt > 0 && cfg_cap != 0 && sum + q_tok[w][0] > {32'd0, cfg_cap}) break;
         ids.push_back(q_id[w][0]);
         sum += q_tok[w][0];
         void'(q_id[w].pop_front());
         void'(q_tok[w].pop_front());
         void'(q_arr[w].pop_front());
         cnt++;
      end
      busy[w] = 1'b1;
      foreach (ids[i]) begin
         x.kind = KIND_ADMIT; x.worker = 2'(w); x.request = ids[i];
         x.bnum = next_bnum; x.btok = sum[19:0]; x.bsize = 5'(cnt); x.last = 1'b0;
         expected_words.push_back(x);
      end
      next_bnum++;
   endfunction

   function automatic void predict_word(row_type r);
      word_type x;
      int nw;
      int base_count;
      bit go;
      if (r.op == OP_ENQUEUE) begin
         x.worker = r.worker; x.request = r.id;
         x.bnum = 0; x.btok = 0; x.bsize = 0; x.last = 1'b1;
         if (r.worker >= WORKER_COUNT || q_id[r.worker].size() >= QUEUE_DEPTH) begin
            x.kind = KIND_REJECT;
         end else begin
            x.kind = KIND_ACCEPT;
            q_id[r.worker].push_back(r.id);
            q_tok[r.worker].push_back(r.tokens);
            q_arr[r.worker].push_back(r.tnow);
         end
         if (r.typed && x.kind != r.xkind) begin
            $error("table kind: expected %0d, predicted %0d", r.xkind, x.kind);
            errors++;
         end
         expected_words.push_back(x);
      end else if (r.op == OP_TICK) begin
         nw = (cfg_active > WORKER_COUNT) ? WORKER_COUNT : cfg_active;
         base_count = expected_words.size();
         for (int i = 0; i < nw; i++) begin
            if (busy[i] || q_id[i].size() == 0) continue;
            go = (cfg_wait == 0);
            if (q_id[i].size() >= ((cfg_batch == 0) ? 1 : cfg_batch)) go = 1'b1;
            if (r.tnow >= q_arr[i][0] && ({1'b0, r.tnow} - {1'b0, q_arr[i][0]}) >= cfg_wait)
               go = 1'b1;
            if (go) launch_batch(i);
         end
         if (expected_words.size() > base_count)
            expected_words[expected_words.size() - 1].last = 1'b1;
      end else if (r.op == OP_DONE) begin
         if (r.worker < WORKER_COUNT) busy[r.worker] = 1'b0;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      word_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word: kind %0d request %0d", rsp_kind, rsp_out_request);
            errors++;
         end else begin
            x = expected_words.pop_front();
            if (rsp_kind !== x.kind) begin
               $error("kind: expected %0d, actual %0d", x.kind, rsp_kind); errors++;
            end
            if (rsp_out_worker !== x.worker) begin
               $error("out_worker: expected %0d, actual %0d", x.worker, rsp_out_worker);
               errors++;
            end
            if (rsp_out_request !== x.request) begin
               $error("out_request: expected %0d, actual %0d", x.request, rsp_out_request);
               errors++;
            end
            if (rsp_batch_number !== x.bnum) begin
               $error("batch_number: expected %0d, actual %0d", x.bnum, rsp_batch_number);
               errors++;
            end
            if (rsp_batch_tokens !== x.btok) begin
               $error("batch_tokens: expected %0d, actual %0d", x.btok, rsp_batch_tokens);
               errors++;
            end
            if (rsp_batch_size !== x.bsize) begin
               $error("batch_size: expected %0d, actual %0d", x.bsize, rsp_batch_size);
               errors++;
            end
            if (rsp_last !== x.last) begin
               $error("last: expected %0d, actual %0d", x.last, rsp_last); errors++;
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      @(posedge clock);
      while (1) begin
         if (!calm && rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_ACTIVE: cfg_active = val[2:0];
         REG_BATCH:  cfg_batch = val[4:0];
         REG_CAP:    cfg_cap = val[31:0];
         default:    cfg_wait = val[39:0];
      endcase
      @(posedge clock);
   endtask

   // valid stays high after acceptance only when the next word follows at once
   task automatic send_word(row_type r);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 10);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1; req_opcode <= r.op; req_worker_index <= r.worker;
      req_request_id <= r.id; req_prompt_tokens <= r.tokens; req_time_ns <= r.tnow;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(r);
   endtask

   task automatic drain_and_settle;
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic row_type mk(logic [1:0] op, logic [1:0] w, logic [7:0] id,
                                  logic [15:0] tk, logic [62:0] t, logic typed,
                                  logic [1:0] xk);
      row_type r;
      r.op = op; r.worker = w; r.id = id; r.tokens = tk; r.tnow = t;
      r.typed = typed; r.xkind = xk;
      return r;
   endfunction

   row_type dtable[$];
   logic [62:0] clock_ns = 63'd1000;

   task automatic random_item(int bias);
      row_type r;
      int p;
      p = $urandom_range(0, 99);
      clock_ns += 63'($urandom_range(0, 400));
      r.typed = 1'b0; r.xkind = KIND_ACCEPT;
      r.worker = 2'($urandom_range(0, 3));
      r.id = 8'($urandom);
      r.tokens = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(0, 3000));
      if ($urandom_range(0, 15) == 0) r.tokens = 16'($urandom);
      if (p < 55 - bias) begin
         r.op = OP_ENQUEUE;
         r.tnow = ($urandom_range(0, 20) == 0) ? 63'({$urandom, $urandom}) : clock_ns;
      end else if (p < 80) begin
         r.op = OP_TICK;
         r.tnow = ($urandom_range(0, 20) == 0) ? 63'({$urandom, $urandom}) : clock_ns;
      end else if (p < 97) begin
         r.op = OP_DONE; r.tnow = 63'({$urandom, $urandom});
      end else begin
         r.op = OP_SPARE; r.tnow = 63'({$urandom, $urandom});
      end
      send_word(r);
   endtask

   initial begin
      for (int i = 0; i < WORKER_COUNT; i++) busy[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes, idle done, unknown op
      dtable.push_back(mk(OP_ENQUEUE, 2'd0, 8'd0, 16'd0, 63'd0, 1, KIND_ACCEPT));
      dtable.push_back(mk(OP_ENQUEUE, 2'd3, 8'hff, 16'hffff, '1, 1, KIND_ACCEPT));
      dtable.push_back(mk(OP_ENQUEUE, 2'd1, 8'h55, 16'h5555, 63'h2aaa_aaaa_aaaa_aaaa, 1,
                          KIND_ACCEPT));
      dtable.push_back(mk(OP_DONE, 2'd2, 8'd0, 16'd0, 63'd0, 0, KIND_ACCEPT));
      dtable.push_back(mk(OP_SPARE, 2'd1, 8'haa, 16'haaaa, 63'h5555, 0, KIND_ACCEPT));
      dtable.push_back(mk(OP_TICK, 2'd0, 8'd0, 16'd0, 63'd5, 0, KIND_ACCEPT));
      dtable.push_back(mk(OP_TICK, 2'd0, 8'd0, 16'd0, 63'd6, 0, KIND_ACCEPT));
      dtable.push_back(mk(OP_DONE, 2'd0, 8'd0, 16'd0, 63'd0, 0, KIND_ACCEPT));
      dtable.push_back(mk(OP_DONE, 2'd1, 8'd0, 16'd0, 63'd0, 0, KIND_ACCEPT));
      dtable.push_back(mk(OP_DONE, 2'd3, 8'd0, 16'd0, 63'd0, 0, KIND_ACCEPT));
      foreach (dtable[i]) send_word(dtable[i]);
      drain_and_settle();

      // fill worker 2 past its depth
      for (int i = 0; i < QUEUE_DEPTH + 2; i++)
         send_word(mk(OP_ENQUEUE, 2'd2, 8'(i), 16'(i * 100), 63'd10, 1,
                      (i < QUEUE_DEPTH) ? KIND_ACCEPT : KIND_REJECT));
      drain_and_settle();

      // extremes: big batches, tight cap, zero active, long wait
      csr_write(REG_BATCH, 64'd31);
      csr_write(REG_CAP, 64'd2500);
      send_word(mk(OP_TICK, 2'd0, 8'd0, 16'd0, 63'd20, 0, KIND_ACCEPT));
      send_word(mk(OP_DONE, 2'd2, 8'd0, 16'd0, 63'd0, 0, KIND_ACCEPT));
      drain_and_settle();
      csr_write(REG_CAP, 64'hffff_ffff);
      csr_write(REG_ACTIVE, 64'd0);
      send_word(mk(OP_TICK, 2'd0, 8'd0, 16'd0, 63'd30, 0, KIND_ACCEPT));
      drain_and_settle();
      csr_write(REG_ACTIVE, 64'd7);
      csr_write(REG_WAIT, 64'hff_ffff_ffff);
      send_word(mk(OP_TICK, 2'd0, 8'd0, 16'd0, 63'd40, 0, KIND_ACCEPT));
      drain_and_settle();

      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(REG_BATCH, 64'd0); csr_write(REG_WAIT, 64'd0);
                     csr_write(REG_CAP, 64'd0); csr_write(REG_ACTIVE, 64'd4); end
            1: begin csr_write(REG_BATCH, 64'd16); csr_write(REG_WAIT, 64'd800); end
            2: begin csr_write(REG_CAP, 64'd4000); csr_write(REG_BATCH, 64'd5);
                     csr_write(REG_ACTIVE, 64'd2); end
            3: begin csr_write(REG_ACTIVE, 64'd1); csr_write(REG_WAIT, 64'd1);
                     csr_write(REG_CAP, 64'd1); end
            4: begin csr_write(REG_ACTIVE, 64'd3); csr_write(REG_CAP, 64'd0);
                     csr_write(REG_BATCH, 64'd8); csr_write(REG_WAIT, 64'd300); end
            default: begin csr_write(REG_ACTIVE, 64'd4); csr_write(REG_BATCH, 64'd3);
                     csr_write(REG_WAIT, 64'd0); calm = 1'b1; end
         endcase
         for (int k = 0; k < 50; k++) begin
            random_item(0);
            if (k == 25 && ph == 1) begin
               req_valid <= 1'b0;
               while (expected_words.size() != 0) @(posedge clock);
            end
         end
         drain_and_settle();
      end

      if (errors == 0)
         $display("prefill_dynamic_batcher_core test passed");
      else
         $display("prefill_dynamic_batcher_core test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("prefill_dynamic_batcher_core test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pdb_pkg.sv
rtl/core/pdb_csr.sv
rtl/core/pdb_out.sv
rtl/core/pdb_engine.sv
rtl/core/prefill_dynamic_batcher_core.sv
tb/tb_prefill_dynamic_batcher_core.sv
